FILE: rtl/fgpr_pkg.sv
// Shared types, constants and the built-in 5x7 font of the glyph page renderer.
// No dependencies; every other file of the block imports this package.
package fgpr_pkg;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int CMD_QUEUE_DEPTH = 2;

	// operation codes of an input item
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// command kinds handed from front to back
	localparam logic [1:0] K_CLEAR  = 2'd0;
	localparam logic [1:0] K_DRAW   = 2'd1;
	localparam logic [1:0] K_READ   = 2'd2;
	localparam logic [1:0] K_RESULT = 2'd3;

	// character codes with a glyph of their own
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPR_A = 8'h41;
	localparam logic [7:0] CH_UPR_Z = 8'h5A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;

	typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [6:0] column_x;
		logic [5:0] row_y;
		logic [2:0] read_page;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       char_dropped;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		glyph_t     glyph;
		logic [6:0] col;
		logic [5:0] row;
		logic [2:0] page;
		out_item_t  res;
	} cmd_t;

	localparam logic [7:0] FONT_DIGITS [10][GLYPH_COLS] = '{
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
	};

	localparam logic [7:0] FONT_UPPER [26][GLYPH_COLS] = '{
		'{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
		'{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
		'{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
		'{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
		'{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
		'{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
		'{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
		'{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
		'{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
		'{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
	};

	localparam logic [7:0] FONT_COLON [GLYPH_COLS] = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
	localparam logic [7:0] FONT_DOT   [GLYPH_COLS] = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
	localparam logic [7:0] FONT_DASH  [GLYPH_COLS] = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};

	// Glyph columns of a character; codes without a glyph give a blank one.
	function automatic glyph_t pick_glyph(input logic [7:0] code);
		glyph_t     g;
		logic [7:0] d_idx;
		logic [7:0] u_idx;
		g = '0;
		d_idx = code - CH_ZERO;
		u_idx = code - CH_UPR_A;
		for (int c = 0; c < GLYPH_COLS; c++) begin
			if (code >= CH_ZERO && code <= CH_NINE) begin
				g[c] = FONT_DIGITS[d_idx[3:0]][c][GLYPH_ROWS-1:0];
			end else if (code >= CH_UPR_A && code <= CH_UPR_Z) begin
				g[c] = FONT_UPPER[u_idx[4:0]][c][GLYPH_ROWS-1:0];
			end else if (code == CH_COLON) begin
				g[c] = FONT_COLON[c][GLYPH_ROWS-1:0];
			end else if (code == CH_DOT) begin
				g[c] = FONT_DOT[c][GLYPH_ROWS-1:0];
			end else if (code == CH_DASH) begin
				g[c] = FONT_DASH[c][GLYPH_ROWS-1:0];
			end
		end
		return g;
	endfunction

endpackage

FILE: rtl/font_glyph_page_renderer_core.sv
// Top level of the glyph page renderer: front end, command queue and back end.
// Depends on fgpr_pkg, fgpr_front, fgpr_cmd_fifo and fgpr_back.
//
// Renders 5x7 font glyphs into a monochrome frame store kept as vertical pages
// of eight rows (one byte per page and column, bit n is row page*8+n). Every
// accepted item gives exactly one result item, in order. Clear zeroes the
// store; draw ORs a glyph in at any pixel row, clipping rows below the panel
// and dropping (char_dropped = 1) a glyph whose column_x+5 reaches the width;
// read returns one byte, zero outside the panel. Items pass through a
// classifying front stage and a two-entry command queue to the back end, which
// owns the store memory (one read and one write port), so a new item is taken
// while an earlier one is still at work. In the back end a draw does ten
// pipelined read-modify-writes (five columns by two pages) plus setup and
// write drain, and a clear writes one store byte per cycle. After reset the
// back end sweeps all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) store bytes to zero,
// one byte a cycle, and holds req_stall high until the sweep is done.
module font_glyph_page_renderer_core import fgpr_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic empty;
	cmd_t head;
	logic init_busy;

	// accept and classify each item, hold it until the queue has room
	fgpr_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.init_busy (init_busy),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	// decouple the two sides so each can stall on its own
	fgpr_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	// carry out commands against the frame store, register one result
	fgpr_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.init_busy (init_busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/fgpr_front.sv
// Front end of the glyph page renderer: accepts items and classifies them into commands.
// Depends on fgpr_pkg.
module fgpr_front import fgpr_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  in_item_t req,
	input  logic     init_busy,
	output logic     push,
	output cmd_t     push_cmd,
	input  logic     full
);

	localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
	localparam logic [8:0] WIDTH_V = 9'(PANEL_WIDTH);
	localparam logic [4:0] PAGES_V = 5'(PAGE_COUNT);

	logic       vld_s1;
	cmd_t       cmd_s1;
	cmd_t       cmd_nx;
	logic       take;
	logic [8:0] right_edge;
	glyph_t     glyph;

	assign req_stall = init_busy | (vld_s1 & full);
	assign take      = req_valid & ~req_stall;
	assign push      = vld_s1 & ~full;
	assign push_cmd  = cmd_s1;

	always_comb begin
		right_edge = {2'b00, req.column_x} + 9'(GLYPH_COLS);
		glyph = pick_glyph(req.char_code);
		cmd_nx = '0;
		cmd_nx.col = req.column_x;
		cmd_nx.row = req.row_y;
		cmd_nx.page = req.read_page;
		cmd_nx.glyph = glyph;
		unique case (req.operation)
			OP_CLEAR: begin
				cmd_nx.kind = K_CLEAR;
			end
			OP_DRAW: begin
				// drop a glyph that reaches the right edge; a blank glyph changes nothing
				if (right_edge >= WIDTH_V) begin
					cmd_nx.kind = K_RESULT;
					cmd_nx.res.char_dropped = 1'b1;
				end else if (glyph == '0) begin
					cmd_nx.kind = K_RESULT;
				end else begin
					cmd_nx.kind = K_DRAW;
				end
			end
			OP_READ: begin
				if ({2'b00, req.column_x} < WIDTH_V && {2'b00, req.read_page} < PAGES_V) begin
					cmd_nx.kind = K_READ;
				end else begin
					cmd_nx.kind = K_RESULT;
				end
			end
			OP_NONE: begin
				cmd_nx.kind = K_RESULT;
			end
			default: begin
				cmd_nx.kind = K_RESULT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take | (vld_s1 & full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_nx;
		end
	end

endmodule

FILE: rtl/fgpr_cmd_fifo.sv
// Short command queue between the front and back of the glyph page renderer.
// Depends on fgpr_pkg.
module fgpr_cmd_fifo import fgpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int PW = $clog2(CMD_QUEUE_DEPTH);

	cmd_t        slot_q [CMD_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(CMD_QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/fgpr_back.sv
// Back end of the glyph page renderer: frame store memory, clear sweeps, glyph
// read-modify-writes, byte reads and the result register. Depends on fgpr_pkg.
module fgpr_back import fgpr_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      init_busy,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
	localparam int DEPTH      = PANEL_WIDTH * PAGE_COUNT;
	localparam int AW         = $clog2(DEPTH);
	localparam int LAST_ROWS  = PANEL_HEIGHT - (PAGE_COUNT - 1) * 8;
	localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);
	localparam logic [4:0] PAGES_V   = 5'(PAGE_COUNT);
	localparam logic [3:0] LAST_PAGE = 4'(PAGE_COUNT - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_DRAW  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;

	logic [2:0]    state_q;
	logic [AW-1:0] sweep_q;
	logic [2:0]    col_q;
	logic          hi_q;
	cmd_t          cmd_q;
	logic          wen_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    bits_s1;
	logic          rsp_vld_q;
	out_item_t     rsp_q;

	logic          slot_free;
	logic          sweep_last;
	logic          col_last;
	logic [6:0]    gcol;
	logic [14:0]   shifted;
	logic [7:0]    draw_byte;
	logic [3:0]    draw_page;
	logic          draw_page_ok;
	logic [7:0]    draw_col;
	logic [AW-1:0] draw_addr;
	logic [AW-1:0] head_addr;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic          rsp_load;
	out_item_t     rsp_next;

	assign init_busy  = (state_q == ST_INIT);
	assign rsp_valid  = rsp_vld_q;
	assign rsp        = rsp_q;
	assign slot_free  = ~rsp_vld_q | ~rsp_stall;
	assign sweep_last = (sweep_q == AW'(DEPTH - 1));
	assign col_last   = (col_q == 3'(GLYPH_COLS - 1));

	// one glyph column shifted into its two pages, clipped at the panel bottom
	always_comb begin
		gcol = cmd_q.glyph[col_q];
		shifted = {8'h00, gcol} << cmd_q.row[2:0];
		draw_page = {1'b0, cmd_q.row[5:3]} + {3'b000, hi_q};
		draw_page_ok = ({1'b0, draw_page} < PAGES_V);
		draw_byte = hi_q ? {1'b0, shifted[14:8]} : shifted[7:0];
		if (draw_page == LAST_PAGE) begin
			draw_byte = draw_byte & LAST_MASK;
		end
		draw_col = {1'b0, cmd_q.col} + {5'b00000, col_q};
		draw_addr = AW'(int'(draw_page) * PANEL_WIDTH + int'(draw_col));
		head_addr = AW'(int'(head.page) * PANEL_WIDTH + int'(head.col));
	end

	always_comb begin
		pop = 1'b0;
		mem_we = 1'b0;
		mem_wa = sweep_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = draw_addr;
		rsp_load = 1'b0;
		rsp_next = '0;
		// write back the byte read in the previous cycle
		if (wen_s1) begin
			mem_we = 1'b1;
			mem_wa = addr_s1;
			mem_wd = rd_q | bits_s1;
		end
		unique case (state_q) inside
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				rsp_load = sweep_last;
			end
			ST_IDLE: begin
				if (!empty && slot_free) begin
					pop = 1'b1;
					if (head.kind == K_READ) begin
						mem_re = 1'b1;
						mem_ra = head_addr;
					end
					if (head.kind == K_RESULT) begin
						rsp_load = 1'b1;
						rsp_next = head.res;
					end
				end
			end
			ST_DRAW: begin
				mem_re = draw_page_ok;
			end
			ST_DRAIN: begin
				rsp_load = 1'b1;
			end
			ST_READ: begin
				rsp_load = 1'b1;
				rsp_next.read_byte = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			sweep_q   <= '0;
			col_q     <= '0;
			hi_q      <= 1'b0;
			wen_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			wen_s1    <= (state_q == ST_DRAW) && draw_page_ok;
			rsp_vld_q <= rsp_load | (rsp_vld_q & rsp_stall);
			unique case (state_q) inside
				ST_INIT, ST_CLEAR: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							K_CLEAR:  state_q <= ST_CLEAR;
							K_DRAW: begin
								col_q   <= '0;
								hi_q    <= 1'b0;
								state_q <= ST_DRAW;
							end
							K_READ:   state_q <= ST_READ;
							K_RESULT: state_q <= ST_IDLE;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DRAW: begin
					hi_q <= ~hi_q;
					if (hi_q) begin
						col_q <= col_q + 1'b1;
						if (col_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN, ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		addr_s1 <= draw_addr;
		bits_s1 <= draw_byte;
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

endmodule
